[rtl/core/esnf_pkg.sv]
// shared constants and controller/datapath interface types for the safe node finder
`timescale 1ns / 1ps
package esnf_pkg;
	localparam int MaxNodesDef = 1024;
	localparam int MaxEdgesDef = 4096;
	localparam int NodeW = 10;
	localparam int CountW = 11;
	localparam int WordIdxW = 4;
	localparam int MaskW = 64;
	localparam int OutLimit = 1024;

	localparam logic OP_ADD = 1'b0;
	localparam logic OP_RUN = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic add_edge;
		logic root_clear;
		logic root_next;
		logic root_start;
		logic edge_rd;
		logic edge_eval;
		logic abandon;
		logic out_start;
		logic out_clr;
		logic out_rd;
		logic out_next;
		logic clr_start;
		logic clr_step;
		logic run_done;
	} esnf_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic root_end;
		logic root_visited;
		logic stack_empty;
		logic edge_end;
		logic edge_match;
		logic tgt_unvisited;
		logic tgt_on_path;
		logic stack_full;
		logic out_last_word;
		logic out_last_bit;
		logic clr_end;
	} esnf_sts_t;
endpackage

[rtl/core/esnf_datapath.sv]
// edge store, node marks, walk stack and mask assembly for the safe node finder
`timescale 1ns / 1ps
module esnf_datapath #(
	parameter int MAX_NODES = esnf_pkg::MaxNodesDef,
	parameter int MAX_EDGES = esnf_pkg::MaxEdgesDef
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  esnf_pkg::esnf_cmd_t                 cmd,
	output esnf_pkg::esnf_sts_t                 sts,
	input  logic [esnf_pkg::CountW-1:0]         node_count,
	input  logic [esnf_pkg::NodeW-1:0]          edge_from,
	input  logic [esnf_pkg::NodeW-1:0]          edge_to,
	output logic [esnf_pkg::WordIdxW-1:0]       word_index,
	output logic [esnf_pkg::MaskW-1:0]          safe_mask,
	output logic                                last_word,
	output logic                                edges_dropped
);
	import esnf_pkg::*;

	localparam int EAW = $clog2(MAX_EDGES);
	localparam int ECW = $clog2(MAX_EDGES + 1);
	localparam int NAW = $clog2(MAX_NODES);
	localparam int SPW = $clog2(MAX_NODES + 1);
	localparam int LIM = (MAX_NODES < OutLimit) ? MAX_NODES : OutLimit;
	localparam int NW  = $clog2(LIM + 1);
	localparam int FRW = NodeW + ECW;

	// effective node count
	logic [NW-1:0] n_eff;
	always_comb begin
		if (node_count == '0)
			n_eff = NW'(1);
		else if ({1'b0, node_count} > (CountW+1)'(LIM))
			n_eff = NW'(LIM);
		else
			n_eff = node_count[NW-1:0];
	end

	// edge store
	logic [NodeW-1:0] src_mem [MAX_EDGES];
	logic [NodeW-1:0] tgt_mem [MAX_EDGES];
	logic [ECW-1:0]   edge_total_q;
	logic             drop_q;
	logic [NodeW-1:0] src_rd_q, tgt_rd_q;

	wire add_ok = (edge_total_q < ECW'(MAX_EDGES)) && ({1'b0, edge_from} < (NodeW+1)'(n_eff))
		&& ({1'b0, edge_to} < (NodeW+1)'(n_eff));

	// walk state
	logic [NodeW:0]   root_q;
	logic [SPW-1:0]   sp_q;
	logic [NodeW-1:0] cur_node_q;
	logic [ECW-1:0]   cur_e_q;
	logic [FRW-1:0]   stk_mem [MAX_NODES];
	logic [FRW-1:0]   stk_rd_q;
	logic             pop_pend_q;

	// mark memories, one bit per node
	logic vis_mem  [MAX_NODES];
	logic path_mem [MAX_NODES];
	logic safe_mem [MAX_NODES];
	logic vis_t_q, path_t_q, vis_r_q;

	always_ff @(posedge clk) begin
		if (cmd.add_edge && add_ok) begin
			src_mem[edge_total_q[EAW-1:0]] <= edge_from;
			tgt_mem[edge_total_q[EAW-1:0]] <= edge_to;
		end
		src_rd_q <= src_mem[cur_e_q[EAW-1:0]];
		tgt_rd_q <= tgt_mem[cur_e_q[EAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_total_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.run_done) begin
			edge_total_q <= '0;
			drop_q <= 1'b0;
		end else if (cmd.add_edge) begin
			if (add_ok) edge_total_q <= edge_total_q + 1'b1;
			else drop_q <= 1'b1;
		end
	end

	wire edge_hit = (src_rd_q == cur_node_q) && ({1'b0, tgt_rd_q} < (NodeW+1)'(n_eff));

	// output scan
	logic [WordIdxW-1:0] ow_q;
	logic [5:0]          ob_q;
	logic [MaskW-1:0]    mask_q;
	logic                bit_val_q;
	logic                bit_ok_q;
	logic [NAW-1:0]      clr_q;
	wire [NodeW+1:0] onode = {2'b0, ow_q, ob_q};
	wire [NodeW+1:0] nwords_m1 = (NodeW+2)'((n_eff + NW'(63)) >> 6) - 1'b1;

	// which mark address this cycle
	logic [NAW-1:0] mark_a;
	always_comb begin
		if (cmd.clr_step) mark_a = clr_q;
		else if (cmd.out_rd) mark_a = onode[NAW-1:0];
		else mark_a = NAW'(tgt_rd_q);
	end

	always_ff @(posedge clk) begin
		// clear, push and pop/done writes
		if (cmd.clr_step) begin
			vis_mem[clr_q] <= 1'b0;
			path_mem[clr_q] <= 1'b0;
			safe_mem[clr_q] <= 1'b0;
		end else if (cmd.root_start) begin
			vis_mem[NAW'(root_q)] <= 1'b1;
			path_mem[NAW'(root_q)] <= 1'b1;
			safe_mem[NAW'(root_q)] <= 1'b0;
		end else if (cmd.edge_eval && edge_hit && !vis_t_q && !sts.stack_full) begin
			vis_mem[NAW'(tgt_rd_q)] <= 1'b1;
			path_mem[NAW'(tgt_rd_q)] <= 1'b1;
			safe_mem[NAW'(tgt_rd_q)] <= 1'b0;
		end else if (cmd.edge_rd && sts.edge_end) begin
			safe_mem[NAW'(cur_node_q)] <= 1'b1;
			path_mem[NAW'(cur_node_q)] <= 1'b0;
		end
		vis_t_q  <= vis_mem[mark_a];
		path_t_q <= path_mem[mark_a];
		bit_val_q <= safe_mem[mark_a];
		vis_r_q  <= vis_mem[NAW'(root_q)];
	end

	// stack frame memory, parent of the top frame is read ahead for a pop
	always_ff @(posedge clk) begin
		if (cmd.edge_eval && edge_hit && !vis_t_q && !sts.stack_full)
			stk_mem[sp_q[NAW-1:0] - 1'b1] <= {cur_node_q, cur_e_q + 1'b1};
		stk_rd_q <= stk_mem[sp_q[NAW-1:0] - NAW'(2)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			root_q <= '0;
			sp_q <= '0;
			cur_node_q <= '0;
			cur_e_q <= '0;
			pop_pend_q <= 1'b0;
			ow_q <= '0;
			ob_q <= '0;
			bit_ok_q <= 1'b0;
			clr_q <= '0;
		end else begin
			pop_pend_q <= 1'b0;
			if (cmd.root_clear) root_q <= '0;
			if (cmd.root_next) root_q <= root_q + 1'b1;
			if (cmd.root_start) begin
				sp_q <= SPW'(1);
				cur_node_q <= root_q[NodeW-1:0];
				cur_e_q <= '0;
			end
			if (pop_pend_q) begin
				// restore parent frame read from stack memory
				cur_node_q <= stk_rd_q[FRW-1:ECW];
				cur_e_q <= stk_rd_q[ECW-1:0];
			end
			if (cmd.edge_rd && sts.edge_end) begin
				sp_q <= sp_q - 1'b1;
				if (sp_q > SPW'(1)) pop_pend_q <= 1'b1;
			end
			if (cmd.edge_eval) begin
				if (!edge_hit) cur_e_q <= cur_e_q + 1'b1;
				else if (!vis_t_q) begin
					if (sts.stack_full) sp_q <= '0;
					else begin
						sp_q <= sp_q + 1'b1;
						cur_node_q <= tgt_rd_q;
						cur_e_q <= '0;
					end
				end else begin
					cur_e_q <= cur_e_q + 1'b1;
					if (path_t_q) sp_q <= '0;
				end
			end
			if (cmd.abandon) sp_q <= '0;
			if (cmd.out_start) begin
				ow_q <= '0;
				ob_q <= '0;
			end
			bit_ok_q <= cmd.out_rd && ((NodeW+2)'(n_eff) > onode);
			if (cmd.out_next) begin
				if (ob_q == 6'd63) ow_q <= ow_q + 1'b1;
				ob_q <= ob_q + 1'b1;
			end
			if (cmd.clr_start) clr_q <= '0;
			if (cmd.clr_step) clr_q <= clr_q + 1'b1;
		end
	end

	// mask word assembly, bit read in the cycle after its address
	logic [5:0] ob_d_q;
	always_ff @(posedge clk) begin
		ob_d_q <= ob_q;
		if (cmd.out_clr) mask_q <= '0;
		else if (bit_ok_q) mask_q[ob_d_q] <= bit_val_q;
	end

	assign safe_mask = mask_q;
	assign word_index = ow_q;
	assign last_word = ((NodeW+2)'(ow_q) == nwords_m1);
	assign edges_dropped = drop_q;

	assign sts.root_end = (root_q >= (NodeW+1)'(n_eff));
	assign sts.root_visited = vis_r_q;
	assign sts.stack_empty = (sp_q == '0);
	assign sts.edge_end = (cur_e_q >= edge_total_q);
	assign sts.edge_match = edge_hit;
	assign sts.tgt_unvisited = !vis_t_q;
	assign sts.tgt_on_path = path_t_q;
	assign sts.stack_full = (sp_q >= SPW'(MAX_NODES));
	assign sts.out_last_word = last_word;
	assign sts.out_last_bit = (ob_q == 6'd63) || ((NodeW+2)'(n_eff) <= onode + 1'b1);
	assign sts.clr_end = (clr_q == NAW'(MAX_NODES - 1));
endmodule

[rtl/core/esnf_ctrl.sv]
// sequencing state machine for loading, walking, emitting and clearing
`timescale 1ns / 1ps
module esnf_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic                op,
	output logic                out_valid,
	input  logic                out_stall,
	output esnf_pkg::esnf_cmd_t cmd,
	input  esnf_pkg::esnf_sts_t sts
);
	import esnf_pkg::*;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] S_RCHK  = 4'd2;
	localparam logic [3:0] S_RWAIT = 4'd3;
	localparam logic [3:0] S_RDEC  = 4'd4;
	localparam logic [3:0] S_ERD   = 4'd5;
	localparam logic [3:0] S_EWAIT = 4'd6;
	localparam logic [3:0] S_EEVAL = 4'd7;
	localparam logic [3:0] S_POP   = 4'd8;
	localparam logic [3:0] S_OBIT  = 4'd9;
	localparam logic [3:0] S_OFIN  = 4'd10;
	localparam logic [3:0] S_OSEND = 4'd11;
	localparam logic [3:0] S_WWAIT = 4'd12;

	logic [3:0] state_q, state_d;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		in_stall = 1'b1;
		out_valid = 1'b0;
		case (state_q)
			S_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_end) state_d = S_IDLE;
			end
			S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					if (op == OP_ADD) cmd.add_edge = 1'b1;
					else begin
						cmd.root_clear = 1'b1;
						state_d = S_RCHK;
					end
				end
			end
			S_RCHK: begin
				if (sts.root_end) begin
					cmd.out_start = 1'b1;
					cmd.out_clr = 1'b1;
					state_d = S_OBIT;
				end else state_d = S_RWAIT;
			end
			S_RWAIT: state_d = S_RDEC;
			S_RDEC: begin
				if (sts.root_visited) begin
					cmd.root_next = 1'b1;
					state_d = S_RCHK;
				end else begin
					cmd.root_start = 1'b1;
					state_d = S_ERD;
				end
			end
			S_ERD: begin
				if (sts.stack_empty) begin
					cmd.root_next = 1'b1;
					state_d = S_RCHK;
				end else begin
					cmd.edge_rd = 1'b1;
					if (sts.edge_end) state_d = S_POP;
					else state_d = S_EWAIT;
				end
			end
			S_POP: state_d = S_ERD;
			S_EWAIT: state_d = S_EEVAL;
			S_EEVAL: begin
				// target marks are valid now
				if (sts.edge_match) begin
					cmd.edge_eval = 1'b1;
					state_d = S_ERD;
				end else begin
					cmd.edge_eval = 1'b1;
					state_d = S_ERD;
				end
			end
			S_OBIT: begin
				cmd.out_rd = 1'b1;
				cmd.out_next = !sts.out_last_bit;
				if (sts.out_last_bit) state_d = S_OFIN;
			end
			S_OFIN: state_d = S_WWAIT;
			S_WWAIT: state_d = S_OSEND;
			S_OSEND: begin
				out_valid = 1'b1;
				if (!out_stall) begin
					if (sts.out_last_word) begin
						cmd.run_done = 1'b1;
						cmd.clr_start = 1'b1;
						state_d = S_CLR;
					end else begin
						cmd.out_next = 1'b1;
						cmd.out_clr = 1'b1;
						state_d = S_OBIT;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLR;
		else state_q <= state_d;
	end
endmodule

[rtl/core/eventual_safe_node_finder.sv]
// Eventual safe node finder: edge beats load a graph; a run beat emits the safe node set.
// Input channel: in_valid/in_stall with op, edge_from, edge_to. op=0 stores one edge;
// edges past capacity or with an endpoint >= node_count (min 1) are dropped and flagged.
// op=1 starts a depth-first walk over the stored edges; every step of the walk reads one
// edge entry from the edge memory, then waits for the target marks and evaluates it.
// Each root node not yet visited by an earlier walk starts a new walk.
// Output channel: out_valid/out_stall with word_index, safe_mask, last_word,
// edges_dropped; ceil(n/64) mask beats, each built from the safe bits.
// A stalled output beat holds until taken; no input is taken during a run.
// After the last beat the marks are swept, one node per cycle, and the edge store is
// emptied. After reset the same sweep runs before the first beat is taken. The user
// writes node_count with cfg_we/cfg_wdata only while idle; the block does not check it.
`timescale 1ns / 1ps
module eventual_safe_node_finder #(
	parameter int MAX_NODES = esnf_pkg::MaxNodesDef,
	parameter int MAX_EDGES = esnf_pkg::MaxEdgesDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [esnf_pkg::CountW-1:0]   cfg_wdata,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic                          op,
	input  logic [esnf_pkg::NodeW-1:0]    edge_from,
	input  logic [esnf_pkg::NodeW-1:0]    edge_to,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [esnf_pkg::WordIdxW-1:0] word_index,
	output logic [esnf_pkg::MaskW-1:0]    safe_mask,
	output logic                          last_word,
	output logic                          edges_dropped
);
	import esnf_pkg::*;

	logic [CountW-1:0] node_count_q;
	esnf_cmd_t cmd;
	esnf_sts_t sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) node_count_q <= CountW'(1);
		else if (cfg_we) node_count_q <= cfg_wdata;
	end

	esnf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall), .op(op),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	esnf_datapath #(.MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts), .node_count(node_count_q),
		.edge_from(edge_from), .edge_to(edge_to), .word_index(word_index),
		.safe_mask(safe_mask), .last_word(last_word), .edges_dropped(edges_dropped)
	);
endmodule

[dv/tb.sv]
// testbench for the eventual safe node finder: random graphs checked against a dfs predictor
`timescale 1ns / 1ps
module tb;
	import esnf_pkg::*;

	localparam int EdgeCap = 4096;
	localparam int NodeCap = 1024;
	localparam int IdleLimit = 400000;
	localparam int SettleCycles = 1300;

	typedef struct {
		logic op;
		logic [NodeW-1:0] src;
		logic [NodeW-1:0] dst;
	} cmd_beat_t;

	typedef struct {
		logic [WordIdxW-1:0] idx;
		logic [MaskW-1:0] mask;
		logic last;
		logic dropped;
	} mask_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CountW-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = OP_ADD;
	logic [NodeW-1:0] edge_from = '0;
	logic [NodeW-1:0] edge_to = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [WordIdxW-1:0] word_index;
	logic [MaskW-1:0] safe_mask;
	logic last_word;
	logic edges_dropped;

	eventual_safe_node_finder u_dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall), .op(op),
		.edge_from(edge_from), .edge_to(edge_to),
		.out_valid(out_valid), .out_stall(out_stall), .word_index(word_index),
		.safe_mask(safe_mask), .last_word(last_word), .edges_dropped(edges_dropped)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// predictor state
	logic [CountW-1:0] node_count_q = 11'd1;
	logic [NodeW-1:0] graph_src[$];
	logic [NodeW-1:0] graph_dst[$];
	logic drop_seen = 1'b0;
	logic visited[NodeCap] = '{default: 1'b0};
	logic on_path[NodeCap] = '{default: 1'b0};
	logic safe_node[NodeCap] = '{default: 1'b0};
	int walk_node[NodeCap];
	int walk_cursor[NodeCap];

	cmd_beat_t pending_beats[$];
	mask_word_t expected_words[$];
	int fail_count = 0;
	int idle_cycles = 0;

	function automatic int live_nodes();
		int n;
		n = node_count_q;
		if (n < 1) n = 1;
		if (n > NodeCap) n = NodeCap;
		return n;
	endfunction

	function automatic void clear_marks();
		for (int i = 0; i < NodeCap; i++) begin
			visited[i] = 1'b0;
			on_path[i] = 1'b0;
			safe_node[i] = 1'b0;
		end
	endfunction

	function automatic void dfs_from(int root, int n);
		int sp, top, nd, e, t;
		walk_node[0] = root;
		walk_cursor[0] = 0;
		sp = 1;
		visited[root] = 1'b1;
		on_path[root] = 1'b1;
		safe_node[root] = 1'b0;
		while (sp > 0) begin
			top = sp - 1;
			nd = walk_node[top];
			e = walk_cursor[top];
			while (e < graph_src.size() && !(graph_src[e] == nd && graph_dst[e] < n))
				e++;
			if (e >= graph_src.size()) begin
				safe_node[nd] = 1'b1;
				on_path[nd] = 1'b0;
				sp--;
			end else begin
				walk_cursor[top] = e + 1;
				t = graph_dst[e];
				if (!visited[t]) begin
					if (sp >= NodeCap) begin
						sp = 0;
					end else begin
						visited[t] = 1'b1;
						on_path[t] = 1'b1;
						safe_node[t] = 1'b0;
						walk_node[sp] = t;
						walk_cursor[sp] = 0;
						sp++;
					end
				end else if (on_path[t]) begin
					// cycle reached: whole walk dropped, path stays unsafe
					sp = 0;
				end
			end
		end
	endfunction

	function automatic void predict_beat(cmd_beat_t b);
		int n, words;
		mask_word_t w;
		n = live_nodes();
		if (b.op == OP_ADD) begin
			if (graph_src.size() >= EdgeCap || b.src >= n || b.dst >= n) begin
				drop_seen = 1'b1;
			end else begin
				graph_src = {graph_src, b.src};
				graph_dst = {graph_dst, b.dst};
			end
		end else begin
			for (int v = 0; v < n; v++)
				if (!visited[v]) dfs_from(v, n);
			words = (n + 63) / 64;
			for (int i = 0; i < words; i++) begin
				w.idx = i[WordIdxW-1:0];
				w.mask = '0;
				for (int k = 0; k < 64; k++)
					if (i * 64 + k < n && safe_node[i * 64 + k]) w.mask[k] = 1'b1;
				w.last = (i + 1 == words);
				w.dropped = drop_seen;
				expected_words = {expected_words, w};
			end
			graph_src.delete();
			graph_dst.delete();
			drop_seen = 1'b0;
			clear_marks();
		end
	endfunction

	// input driver
	logic in_taken = 1'b0;
	int in_gap = 0;
	logic in_calm = 1'b0;

	function automatic int pick_gap(logic calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	always @(posedge clk) begin
		in_taken <= in_valid && !in_stall;
		if (in_valid && !in_stall) begin
			predict_beat('{op, edge_from, edge_to});
		end
	end

	always @(negedge clk) begin
		cmd_beat_t b;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !in_taken) begin
			// stalled beat held as is
		end else begin
			if ($urandom_range(0, 199) == 0) in_calm = ~in_calm;
			if (in_valid) in_gap = pick_gap(in_calm);
			if (in_gap > 0) begin
				in_gap--;
				in_valid <= 1'b0;
			end else if (pending_beats.size() > 0) begin
				b = pending_beats.pop_front();
				op <= b.op;
				edge_from <= b.src;
				edge_to <= b.dst;
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side
	int out_gap = 0;
	int hold_left = 0;
	logic hold_armed = 1'b0;
	logic hold_done = 1'b0;

	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (hold_armed && !hold_done && out_valid) begin
			hold_done = 1'b1;
			hold_left = 3000;
			out_stall <= 1'b1;
		end else if (out_gap > 0) begin
			out_gap--;
			out_stall <= 1'b1;
		end else begin
			out_gap = pick_gap(in_calm);
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		mask_word_t w;
		if (out_valid && !out_stall) begin
			if (expected_words.size() == 0) begin
				$error("unexpected mask word idx=%0d", word_index);
				fail_count++;
			end else begin
				w = expected_words.pop_front();
				if (word_index !== w.idx) begin
					$error("word_index exp %0d got %0d", w.idx, word_index);
					fail_count++;
				end
				if (safe_mask !== w.mask) begin
					$error("safe_mask exp %h got %h", w.mask, safe_mask);
					fail_count++;
				end
				if (last_word !== w.last) begin
					$error("last_word exp %0d got %0d", w.last, last_word);
					fail_count++;
				end
				if (edges_dropped !== w.dropped) begin
					$error("edges_dropped exp %0d got %0d", w.dropped, edges_dropped);
					fail_count++;
				end
			end
		end
	end

	// watchdog on beats moving
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IdleLimit) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	task automatic push_edge(int s, int d);
		cmd_beat_t b;
		b.op = OP_ADD;
		b.src = s[NodeW-1:0];
		b.dst = d[NodeW-1:0];
		pending_beats = {pending_beats, b};
	endtask

	task automatic push_run();
		cmd_beat_t b;
		b.op = OP_RUN;
		b.src = NodeW'($urandom());
		b.dst = NodeW'($urandom());
		pending_beats = {pending_beats, b};
	endtask

	task automatic drain();
		wait (pending_beats.size() == 0 && !in_valid && expected_words.size() == 0);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic set_nodes(int value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value[CountW-1:0];
		node_count_q = value[CountW-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// random graph, mostly valid edges, a few out of range
	task automatic random_graph(int n, int max_e);
		int ne;
		ne = $urandom_range(0, max_e);
		for (int i = 0; i < ne; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_edge($urandom_range(0, 1023), $urandom_range(0, 1023));
			else if ($urandom_range(0, 3) == 0 && n > 1)
				push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1) / 2);
			else
				push_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1));
		end
		push_run();
	endtask

	initial begin
		int settings[8] = '{2047, 0, 64, 1024, 1, 37, 130, 2047};
		int n;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: chain, self loop, drops, empty runs
		set_nodes(4);
		push_edge(0, 1); push_edge(1, 3); push_edge(2, 2);
		push_edge(4, 0); push_edge(0, 5);
		push_run();
		push_run();
		push_edge(0, 1); push_edge(1, 0); push_edge(1, 2); push_edge(3, 2);
		push_run();
		drain();
		set_nodes(1024);
		push_edge(1023, 1023); push_edge(0, 1023); push_edge(682, 341);
		push_edge(341, 682); push_edge(1, 0); push_edge(1022, 1);
		push_run();
		drain();
		// nodes shrink after loading
		set_nodes(8);
		push_edge(0, 7); push_edge(7, 0); push_edge(1, 2);
		drain();
		set_nodes(5);
		push_run();
		drain();

		for (int p = 0; p < 8; p++) begin
			set_nodes(settings[p]);
			n = live_nodes();
			if (p == 2) hold_armed = 1'b1;
			for (int g = 0; g < 6; g++) begin
				if (n > 128) random_graph(n, 16);
				else random_graph(n, (3 * n < 30) ? 3 * n : 30);
			end
			drain();
		end
		for (int g = 0; g < 2; g++) begin
			set_nodes($urandom_range(2, 70));
			random_graph(live_nodes(), 24);
			drain();
		end

		if (fail_count == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end
endmodule
